// ===== rtl/trimmed_mean_drop_max_min_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the trimmed mean block.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_DROP_MAX_MIN_ASSERT_SVH
`define TRIMMED_MEAN_DROP_MAX_MIN_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trm_pkg.sv =====
// ----------------------------------------------------------------------------
// trm_pkg
// Types and constants shared by the trimmed mean block.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int unsigned MAX_SCORES_DEF = 128;
  localparam int unsigned SCORE_BITS_DEF = 16;

  // Fixed payload widths
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned MEAN_W  = 23;

  // Smallest set that leaves something after trimming
  localparam int unsigned MIN_SET = 3;

  // Mean in hundredths, doubled so the rounding offset is the divisor itself
  localparam int unsigned SCALE      = 200;
  localparam int unsigned SCALE_BITS = $clog2(SCALE);

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TRIM  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } trm_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } trm_qstat_t;

endpackage

// ===== rtl/trm_if.sv =====
// ----------------------------------------------------------------------------
// trm_if
// Valid/ready channels for scores in and trimmed means out.
// ----------------------------------------------------------------------------
interface trm_score_if;
  logic                         valid;
  logic                         ready;
  logic [trm_pkg::SCORE_W-1:0]  score;
  logic                         last;

  modport source (output valid, output score, output last, input ready);
  modport sink   (input valid, input score, input last, output ready);
endinterface

interface trm_mean_if;
  logic                        valid;
  logic                        ready;
  logic [trm_pkg::MEAN_W-1:0]  mean_hundredths;
  logic                        bad_count;

  modport source (output valid, output mean_hundredths, output bad_count, input ready);
  modport sink   (input valid, input mean_hundredths, input bad_count, output ready);
endinterface

// ===== rtl/trm_front.sv =====
// ----------------------------------------------------------------------------
// trm_front
// Accepts scores, keeps count, sum, maximum and minimum of the current set,
// and pushes one job per set into the queue on the last score.
// ----------------------------------------------------------------------------
module trm_front #(
  parameter int unsigned MAX_SCORES = trm_pkg::MAX_SCORES_DEF,
  parameter int unsigned SCORE_BITS = trm_pkg::SCORE_BITS_DEF,
  parameter int unsigned CNT_W      = $clog2(MAX_SCORES + 1),
  parameter int unsigned SUM_W      = SCORE_BITS + CNT_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [trm_pkg::SCORE_W-1:0] score_i,
  input  logic                        last_i,
  input  trm_pkg::trm_qstat_t         qstat_i,
  output logic                        push_o,
  output logic [SUM_W-1:0]            job_sum_o,
  output logic [SCORE_BITS-1:0]       job_max_o,
  output logic [SCORE_BITS-1:0]       job_min_o,
  output logic [CNT_W-1:0]            job_cnt_o,
  output logic                        job_bad_o
);
  import trm_pkg::*;

  logic [SCORE_BITS-1:0] s;
  logic                  accept;
  logic                  room;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [SCORE_BITS-1:0] max_q, max_d;
  logic [SCORE_BITS-1:0] min_q, min_d;
  logic                  ovf_q, ovf_d;

  assign s          = SCORE_BITS'(score_i);
  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign room       = cnt_q < CNT_W'(MAX_SCORES);

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    ovf_d = ovf_q;
    if (room) begin
      cnt_d = cnt_q + 1'b1;
      sum_d = sum_q + SUM_W'(s);
      if (s > max_q) max_d = s;
      if (s < min_q) min_d = s;
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o    = accept && last_i;
  assign job_sum_o = sum_d;
  assign job_max_o = max_d;
  assign job_min_o = min_d;
  assign job_cnt_o = cnt_d;
  assign job_bad_o = ovf_d || (cnt_d < CNT_W'(MIN_SET));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      max_q <= '0;
      min_q <= '1;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        // clear for the next set
        cnt_q <= '0;
        sum_q <= '0;
        max_q <= '0;
        min_q <= '1;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        max_q <= max_d;
        min_q <= min_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule

// ===== rtl/trm_queue.sv =====
// ----------------------------------------------------------------------------
// trm_queue
// Short job queue between the accumulating front and the dividing back.
// ----------------------------------------------------------------------------
module trm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = trm_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output trm_pkg::trm_qstat_t qstat_o
);
  import trm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign data_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = count_q == CNT_W'(DEPTH);
  assign qstat_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== rtl/trm_back.sv =====
// ----------------------------------------------------------------------------
// trm_back
// Takes one job at a time: trims the extremes, scales by 200 and adds the
// rounding offset, then divides by twice the remaining count bit-serially. A flagged job skips to a zero mean.
// ----------------------------------------------------------------------------
module trm_back #(
  parameter int unsigned MAX_SCORES = trm_pkg::MAX_SCORES_DEF,
  parameter int unsigned SCORE_BITS = trm_pkg::SCORE_BITS_DEF,
  parameter int unsigned CNT_W      = $clog2(MAX_SCORES + 1),
  parameter int unsigned SUM_W      = SCORE_BITS + CNT_W,
  parameter int unsigned NUM_W      = SUM_W + trm_pkg::SCALE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  trm_pkg::trm_qstat_t        qstat_i,
  output logic                       pop_o,
  input  logic [SUM_W-1:0]           job_sum_i,
  input  logic [SCORE_BITS-1:0]      job_max_i,
  input  logic [SCORE_BITS-1:0]      job_min_i,
  input  logic [CNT_W-1:0]           job_cnt_i,
  input  logic                       job_bad_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [trm_pkg::MEAN_W-1:0] mean_o,
  output logic                       bad_o
);
  import trm_pkg::*;
  `include "trimmed_mean_drop_max_min_assert.svh"

  localparam int unsigned ITER_W = $clog2(NUM_W);

  trm_state_e          state_q, state_d;
  logic [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]    ext_q;
  logic [CNT_W-1:0]    d_q;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [CNT_W:0]      rem_q, rem_d;
  logic [ITER_W-1:0]   iter_q;
  logic                bad_job_q;

  logic                out_valid_q;
  logic [MEAN_W-1:0]   mean_q;
  logic                bad_q;

  logic [CNT_W+1:0]    rem_sh;
  logic [CNT_W+1:0]    den;
  logic                ge;
  logic                load_out;

  // one restoring division step
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign den    = {1'b0, d_q, 1'b0};
  assign ge     = rem_sh >= den;
  assign rem_d  = ge ? (CNT_W+1)'(rem_sh - den) : (CNT_W+1)'(rem_sh);
  assign num_d  = {num_q[NUM_W-2:0], ge};

  assign pop_o    = (state_q == ST_IDLE) && !qstat_i.empty;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (!qstat_i.empty) state_d = job_bad_i ? ST_DONE : ST_TRIM;
      ST_TRIM:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV:   if (iter_q == '0) state_d = ST_DONE;
      ST_DONE:  if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sum_q     <= job_sum_i;
        ext_q     <= SUM_W'(job_max_i) + SUM_W'(job_min_i);
        d_q       <= job_cnt_i - CNT_W'(2);
        bad_job_q <= job_bad_i;
        num_q     <= '0;
      end
      ST_TRIM: begin
        num_q <= NUM_W'(sum_q - ext_q);
      end
      ST_SCALE: begin
        // doubled scale plus divisor/2 gives round half up after /(2d)
        num_q  <= num_q * NUM_W'(SCALE) + NUM_W'(d_q);
        rem_q  <= '0;
        iter_q <= ITER_W'(NUM_W - 1);
      end
      ST_DIV: begin
        num_q  <= num_d;
        rem_q  <= rem_d;
        iter_q <= iter_q - 1'b1;
      end
      ST_DONE: begin
        if (load_out) begin
          mean_q <= bad_job_q ? '0 : MEAN_W'(num_q);
          bad_q  <= bad_job_q;
        end
      end
      default: begin
        num_q <= num_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign mean_o      = mean_q;
  assign bad_o       = bad_q;

  `TRM_ASSERT_SAME(a_pop_nonempty, clk_i, rst_ni, pop_o, !qstat_i.empty, "pop from empty queue")
  `TRM_ASSERT_SAME(a_bad_zero, clk_i, rst_ni, out_valid_o && bad_o, mean_o == '0, "bad set with nonzero mean")
  `TRM_ASSERT_NEXT(a_done_fills, clk_i, rst_ni, (state_q == ST_DONE) && !out_valid_q, out_valid_q, "finished result not loaded")
  `TRM_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, (state_q == ST_DIV) && (iter_q != '0), state_q == ST_DIV, "division left early")

endmodule

// ===== rtl/trimmed_mean_drop_max_min.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_drop_max_min
// Olympic average: drops one largest and one smallest score of each set and
// returns the mean of the rest in hundredths, rounded half up.
// ----------------------------------------------------------------------------
//  channel   dir  payload                       transfer
//  score_i   in   score[15:0], last             valid && ready
//  mean_o    out  mean_hundredths[22:0], bad    valid && ready
//
//  A score passes through the front whenever the job queue has room; it stalls
//  only while the queue is full. The back takes one set at a time and runs a
//  one-bit-per-cycle restoring divider for each good set; a flagged set skips
//  the trim, scale and division. Up to two finished sets wait in the queue
//  while a result waits on mean_o. Asynchronous active-low reset clears all
//  set state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module trimmed_mean_drop_max_min #(
  parameter int unsigned MAX_SCORES = trm_pkg::MAX_SCORES_DEF,
  parameter int unsigned SCORE_BITS = trm_pkg::SCORE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  trm_score_if.sink score_i,
  trm_mean_if.source mean_o
);
  import trm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SCORES + 1);
  localparam int unsigned SUM_W = SCORE_BITS + CNT_W;
  localparam int unsigned NUM_W = SUM_W + SCALE_BITS;
  localparam int unsigned JOB_W = SUM_W + 2 * SCORE_BITS + CNT_W + 1;

  trm_qstat_t            qstat;
  logic                  push, pop;
  logic [SUM_W-1:0]      f_sum, b_sum;
  logic [SCORE_BITS-1:0] f_max, f_min, b_max, b_min;
  logic [CNT_W-1:0]      f_cnt, b_cnt;
  logic                  f_bad, b_bad;
  logic [JOB_W-1:0]      q_in, q_out;

  trm_front #(
    .MAX_SCORES (MAX_SCORES),
    .SCORE_BITS (SCORE_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (score_i.valid),
    .in_ready_o (score_i.ready),
    .score_i    (score_i.score),
    .last_i     (score_i.last),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_sum_o  (f_sum),
    .job_max_o  (f_max),
    .job_min_o  (f_min),
    .job_cnt_o  (f_cnt),
    .job_bad_o  (f_bad)
  );

  assign q_in = {f_bad, f_cnt, f_min, f_max, f_sum};

  trm_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .pop_i   (pop),
    .data_o  (q_out),
    .qstat_o (qstat)
  );

  assign {b_bad, b_cnt, b_min, b_max, b_sum} = q_out;

  trm_back #(
    .MAX_SCORES (MAX_SCORES),
    .SCORE_BITS (SCORE_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .NUM_W      (NUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .job_sum_i   (b_sum),
    .job_max_i   (b_max),
    .job_min_i   (b_min),
    .job_cnt_i   (b_cnt),
    .job_bad_i   (b_bad),
    .out_valid_o (mean_o.valid),
    .out_ready_i (mean_o.ready),
    .mean_o      (mean_o.mean_hundredths),
    .bad_o       (mean_o.bad_count)
  );

endmodule
